// File: src/rme_pkg.sv
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles: shared definitions
// Widths, angle constants, the CORDIC arctangent table and the input bundle.
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int unsigned DW = 32;            // Q2.30 matrix element width
  localparam int unsigned OW = 31;            // Q3.28 angle width on the ports
  localparam int unsigned TW = 31;            // threshold register width
  localparam int unsigned CW = 36;            // CORDIC x/y datapath width
  localparam int unsigned ZW = 32;            // CORDIC angle accumulator width
  localparam int unsigned RW = 2 * DW;        // radicand width
  localparam int unsigned SQ_STEPS = RW / 2;  // one root bit per stage
  localparam int unsigned CORDIC_STEPS = 28;
  localparam int unsigned CORDIC_LAT = CORDIC_STEPS + 2;
  // Registers from the input transfer to the result strobe.
  localparam int unsigned LATENCY = 3 + SQ_STEPS + 1 + CORDIC_LAT;

  localparam int unsigned AW = 3;             // APB address width
  localparam logic REG_THRESH = 1'b0;         // register index (paddr bit 2)
  localparam logic [TW-1:0] THRESH_RST = TW'(1074);

  localparam logic signed [ZW-1:0] PI_Q = ZW'(843314857);
  localparam logic signed [ZW-1:0] HALF_PI_Q = ZW'(421657428);

  typedef struct packed {
    logic signed [DW-1:0] r00;
    logic signed [DW-1:0] r10;
    logic signed [DW-1:0] r20;
    logic signed [DW-1:0] r21;
    logic signed [DW-1:0] r22;
    logic signed [DW-1:0] r11;
    logic signed [DW-1:0] r12;
  } rot_t;

  // atan(2^-i) in Q3.28, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_q(int i);
    logic signed [ZW-1:0] r;
    unique case (i)
      0: r = ZW'(210828714);
      1: r = ZW'(124459457);
      2: r = ZW'(65760959);
      3: r = ZW'(33381290);
      4: r = ZW'(16755422);
      5: r = ZW'(8385879);
      6: r = ZW'(4193963);
      7: r = ZW'(2097109);
      8: r = ZW'(1048571);
      9: r = ZW'(524287);
      default: begin
        // Beyond this point the cubic term is far below half an LSB.
        if (i <= 28) r = ZW'(1) <<< (28 - i);
        else if (i == 29) r = ZW'(1);
        else r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

// File: src/rme_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit radicand, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module rme_isqrt import rme_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [RW-1:0]   rad_i,
  output logic            valid_o,
  output logic [DW-1:0]   root_o
);

  logic [RW-1:0] rem_q [SQ_STEPS];
  logic [RW-1:0] res_q [SQ_STEPS];
  logic          vld_q [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
    localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * k);
    logic [RW-1:0] rem_in, res_in, trial, rem_d, res_d;
    logic          vld_in;

    if (k == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    assign trial = res_in + BIT;

    always_comb begin
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        res_d = (res_in >> 1) + BIT;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k] <= 1'b0;
      else vld_q[k] <= vld_in;
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      res_q[k] <= res_d;
    end
  end

  assign valid_o = vld_q[SQ_STEPS-1];
  assign root_o  = res_q[SQ_STEPS-1][DW-1:0];

endmodule

// File: src/rme_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC arctangent
// Vectoring-mode atan2(y, x) with quadrant fold, one iteration per stage.
// ----------------------------------------------------------------------------
module rme_cordic import rme_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [DW:0]   y_i,
  input  logic signed [DW:0]   x_i,
  output logic                 valid_o,
  output logic signed [OW-1:0] angle_o
);

  logic signed [CW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_q [CORDIC_STEPS+1];
  logic                 fix_q [CORDIC_STEPS+1];
  logic                 vld_q [CORDIC_STEPS+1];

  logic signed [CW-1:0] xe, ye, x0, y0;
  logic signed [ZW-1:0] z0;
  logic                 fix0;

  assign xe = CW'(x_i);
  assign ye = CW'(y_i);

  // Axis cases are settled here; the left half-plane is turned by 90 degrees.
  always_comb begin
    x0   = xe;
    y0   = ye;
    z0   = '0;
    fix0 = 1'b0;
    priority if (y_i == 0) begin
      fix0 = 1'b1;
      z0   = (x_i < 0) ? PI_Q : '0;
    end else if (x_i == 0) begin
      fix0 = 1'b1;
      z0   = (y_i > 0) ? HALF_PI_Q : -HALF_PI_Q;
    end else if (x_i < 0) begin
      if (y_i > 0) begin
        x0 = ye;
        y0 = -xe;
        z0 = HALF_PI_Q;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -HALF_PI_Q;
      end
    end else begin
      z0 = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else vld_q[0] <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    x_q[0]   <= x0;
    y_q[0]   <= y0;
    z_q[0]   <= z0;
    fix_q[0] <= fix0;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ANG = atan_q(i);
    logic signed [CW-1:0] x_d, y_d;
    logic signed [ZW-1:0] z_d;

    always_comb begin
      x_d = x_q[i];
      y_d = y_q[i];
      z_d = z_q[i];
      if (!fix_q[i]) begin
        if (y_q[i] >= 0) begin
          x_d = x_q[i] + (y_q[i] >>> i);
          y_d = y_q[i] - (x_q[i] >>> i);
          z_d = z_q[i] + ANG;
        end else begin
          x_d = x_q[i] - (y_q[i] >>> i);
          y_d = y_q[i] + (x_q[i] >>> i);
          z_d = z_q[i] - ANG;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[i+1] <= 1'b0;
      else vld_q[i+1] <= vld_q[i];
    end

    always_ff @(posedge clk_i) begin
      x_q[i+1]   <= x_d;
      y_q[i+1]   <= y_d;
      z_q[i+1]   <= z_d;
      fix_q[i+1] <= fix_q[i];
    end
  end

  logic signed [ZW-1:0] z_end, z_sat;
  logic                 out_vld_q;
  logic signed [OW-1:0] angle_q;

  assign z_end = z_q[CORDIC_STEPS];

  always_comb begin
    priority if (z_end > PI_Q) z_sat = PI_Q;
    else if (z_end < -PI_Q) z_sat = -PI_Q;
    else z_sat = z_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else out_vld_q <= vld_q[CORDIC_STEPS];
  end

  always_ff @(posedge clk_i) begin
    angle_q <= z_sat[OW-1:0];
  end

  assign valid_o = out_vld_q;
  assign angle_o = angle_q;

endmodule

// File: src/rotation_matrix_to_euler.sv
// ----------------------------------------------------------------------------
// Rotation matrix to ZYX Euler angles
// Column norm by a pipelined square root, then three pipelined CORDIC
// arctangents for roll, pitch and yaw, with a gimbal-lock fallback.
// ----------------------------------------------------------------------------
// Channel   Signals                               Handshake
// input     rot_*_i                               start high, busy low
// result    roll/pitch/yaw_angle_o, is_singular_o valid_o strobe, one cycle
// config    psel penable pwrite paddr pwdata      APB, pready tied high
//
// One matrix transfer is taken every cycle; busy never rises.
// Each result passes through the input register, the squaring and sum stages,
// 32 square root stages, one select stage, and the 28-step CORDIC with its
// fold and saturation stages.
// Reset clears every valid bit in flight and loads the threshold default.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler import rme_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [DW-1:0] rot_00_i,
  input  logic signed [DW-1:0] rot_10_i,
  input  logic signed [DW-1:0] rot_20_i,
  input  logic signed [DW-1:0] rot_21_i,
  input  logic signed [DW-1:0] rot_22_i,
  input  logic signed [DW-1:0] rot_11_i,
  input  logic signed [DW-1:0] rot_12_i,
  output logic                 valid_o,
  output logic signed [OW-1:0] roll_angle_o,
  output logic signed [OW-1:0] pitch_angle_o,
  output logic signed [OW-1:0] yaw_angle_o,
  output logic                 is_singular_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AW-1:0]        paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // Configuration register.
  logic [TW-1:0] thr_q;
  logic          reg_idx;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_THRESH) ? {1'b0, thr_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RST;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_THRESH) begin
      thr_q <= pwdata[TW-1:0];
    end
  end

  // Input, squaring and sum stages.
  logic          acc;
  rot_t          in_rot, in_q, prd_q, sum_rot_q;
  logic          in_vld_q, prd_vld_q, sum_vld_q;
  logic [DW-1:0] mag00, mag10;
  logic [RW-1:0] sq00_q, sq10_q, sum_q;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  assign in_rot = '{r00: rot_00_i, r10: rot_10_i, r20: rot_20_i, r21: rot_21_i,
                    r22: rot_22_i, r11: rot_11_i, r12: rot_12_i};

  assign mag00 = in_q.r00[DW-1] ? DW'(-in_q.r00) : DW'(in_q.r00);
  assign mag10 = in_q.r10[DW-1] ? DW'(-in_q.r10) : DW'(in_q.r10);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      prd_vld_q <= 1'b0;
      sum_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= acc;
      prd_vld_q <= in_vld_q;
      sum_vld_q <= prd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) in_q <= in_rot;
    prd_q     <= in_q;
    sq00_q    <= RW'(mag00) * RW'(mag00);
    sq10_q    <= RW'(mag10) * RW'(mag10);
    sum_rot_q <= prd_q;
    sum_q     <= sq00_q + sq10_q;
  end

  // Column norm; the matrix elements ride alongside the root stages.
  logic          sq_vld;
  logic [DW-1:0] root;
  rot_t          dly_q [SQ_STEPS];

  rme_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_vld_q),
    .rad_i   (sum_q),
    .valid_o (sq_vld),
    .root_o  (root)
  );

  always_ff @(posedge clk_i) begin
    dly_q[0] <= sum_rot_q;
    for (int k = 1; k < SQ_STEPS; k++) dly_q[k] <= dly_q[k-1];
  end

  // Operand select. A singular yaw feeds atan2(0, 0), which yields zero.
  rot_t               sr;
  logic               sing;
  logic               sel_vld_q, sing_q;
  logic signed [DW:0] py_q, px_q, ry_q, rx_q, yy_q, yx_q;

  assign sr   = dly_q[SQ_STEPS-1];
  assign sing = root < DW'(thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sel_vld_q <= 1'b0;
    else sel_vld_q <= sq_vld;
  end

  always_ff @(posedge clk_i) begin
    sing_q <= sing;
    py_q   <= -(DW+1)'(sr.r20);
    px_q   <= (DW+1)'({1'b0, root});
    ry_q   <= sing ? -(DW+1)'(sr.r12) : (DW+1)'(sr.r21);
    rx_q   <= sing ? (DW+1)'(sr.r11) : (DW+1)'(sr.r22);
    yy_q   <= sing ? '0 : (DW+1)'(sr.r10);
    yx_q   <= sing ? '0 : (DW+1)'(sr.r00);
  end

  // Arctangents.
  logic pv, rv, yv;
  logic sing_dly_q [CORDIC_LAT];

  rme_cordic u_pitch (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (sel_vld_q),
    .y_i (py_q), .x_i (px_q), .valid_o (pv), .angle_o (pitch_angle_o)
  );

  rme_cordic u_roll (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (sel_vld_q),
    .y_i (ry_q), .x_i (rx_q), .valid_o (rv), .angle_o (roll_angle_o)
  );

  rme_cordic u_yaw (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (sel_vld_q),
    .y_i (yy_q), .x_i (yx_q), .valid_o (yv), .angle_o (yaw_angle_o)
  );

  always_ff @(posedge clk_i) begin
    sing_dly_q[0] <= sing_q;
    for (int k = 1; k < CORDIC_LAT; k++) sing_dly_q[k] <= sing_dly_q[k-1];
  end

  assign valid_o       = pv && rv && yv;
  assign is_singular_o = sing_dly_q[CORDIC_LAT-1];

endmodule

// File: src/rme_checker.sv
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles: port checker
// Latency, angle range, singular-case and APB ready checks seen from the top-level ports.
// ----------------------------------------------------------------------------
module rme_checker import rme_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 valid_o,
  input logic signed [OW-1:0] roll_angle_o,
  input logic signed [OW-1:0] pitch_angle_o,
  input logic signed [OW-1:0] yaw_angle_o,
  input logic                 is_singular_o,
  input logic                 psel,
  input logic                 penable,
  input logic                 pready
);

  localparam int unsigned UPW = $clog2(LATENCY + 1);
  localparam logic signed [OW-1:0] PI_O = PI_Q[OW-1:0];

  // Counts cycles since reset so that history checks only look at live cycles.
  logic [UPW-1:0] up_q;
  logic           up_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) up_q <= '0;
    else if (up_q != UPW'(LATENCY)) up_q <= up_q + 1'b1;
  end

  assign up_ok = (up_q == UPW'(LATENCY));

  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    up_ok && $past(start && !busy, LATENCY) |-> valid_o)
    else $error("input transfer without a result at the expected latency");

  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    up_ok && valid_o |-> $past(start && !busy, LATENCY))
    else $error("result without a matching input transfer");

  a_sing_yaw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && is_singular_o |-> yaw_angle_o == '0)
    else $error("singular result with nonzero yaw");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> roll_angle_o >= -PI_O && roll_angle_o <= PI_O &&
                pitch_angle_o >= -PI_O && pitch_angle_o <= PI_O)
    else $error("angle outside plus or minus pi");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("APB access stalled");

endmodule

bind rotation_matrix_to_euler rme_checker u_rme_checker (.*);
